### src/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash save command controller package
// Sizes, bus addresses, command codes and shared types of the controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

   // Array geometry. BANK_BYTES and SECTOR_BYTES are powers of two.
   localparam int BANK_BYTES   = 65536;
   localparam int BANK_COUNT   = 2;
   localparam int SECTOR_BYTES = 4096;
   localparam int TOTAL_BYTES  = BANK_BYTES * BANK_COUNT;

   localparam int OFS_W = $clog2(BANK_BYTES);
   localparam int MEM_AW = (TOTAL_BYTES > 1) ? $clog2(TOTAL_BYTES) : 1;

   localparam int ADDR_W      = 28;
   localparam int DATA_W      = 8;
   localparam int REQ_TDATA_W = 40;
   localparam int CSR_IDX_W   = 1;

   localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = 28'hE005555;
   localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = 28'hE002AAA;
   localparam logic [ADDR_W-1:0] ID_ADDR_MAKER = 28'hE000000;
   localparam logic [ADDR_W-1:0] ID_ADDR_PART  = 28'hE000001;

   localparam logic [DATA_W-1:0] UNLOCK_BYTE_A = 8'hAA;
   localparam logic [DATA_W-1:0] UNLOCK_BYTE_B = 8'h55;
   localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

   localparam logic [DATA_W-1:0] CMD_ID_ENTER    = 8'h90;
   localparam logic [DATA_W-1:0] CMD_ID_EXIT     = 8'hF0;
   localparam logic [DATA_W-1:0] CMD_ERASE_ARM   = 8'h80;
   localparam logic [DATA_W-1:0] CMD_CHIP_ERASE  = 8'h10;
   localparam logic [DATA_W-1:0] CMD_SECT_ERASE  = 8'h30;
   localparam logic [DATA_W-1:0] CMD_WRITE_ARM   = 8'hA0;
   localparam logic [DATA_W-1:0] CMD_BANK_ARM    = 8'hB0;

   localparam logic [CSR_IDX_W-1:0] CSR_MAKER_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_ID  = 1'd1;

   localparam logic [MEM_AW-1:0] SECTOR_MASK = MEM_AW'(SECTOR_BYTES - 1);
   localparam logic [MEM_AW-1:0] LAST_CELL   = MEM_AW'(TOTAL_BYTES - 1);

   typedef enum logic [2:0] {
      MODE_READY,
      MODE_UNLOCK1,
      MODE_UNLOCK2,
      MODE_CHIPID,
      MODE_ERASE_ARMED,
      MODE_WRITE_ARMED,
      MODE_BANK_ARMED
   } mode_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_READ
   } seq_type;

   typedef struct packed {
      logic              go;
      logic [MEM_AW-1:0] first;
      logic [MEM_AW-1:0] last;
   } sweep_cmd_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
   } mem_ctl_type;

   typedef struct packed {
      logic load;
      logic id_hit;
      logic id_part;
   } rsp_ctl_type;

   // Array cell of a bus address in the given bank.
   function automatic logic [MEM_AW-1:0] cell_addr(input logic bank,
                                                    input logic [ADDR_W-1:0] addr);
      logic bank_eff;
      bank_eff = (BANK_COUNT > 1) ? bank : 1'b0;
      return MEM_AW'({bank_eff, addr[OFS_W-1:0]});
   endfunction

endpackage

### src/fsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fsc_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Erase sweep unit
// Walks a range of array cells one per cycle so that each can be erased.
// ----------------------------------------------------------------------------
module fsc_sweep
   import fsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sweep_cmd_type     sweep_cmd,
   output logic              busy,
   output logic [MEM_AW-1:0] cur_addr
);

   logic              busy_ff, busy_in;
   logic [MEM_AW-1:0] cnt_ff, cnt_in;
   logic [MEM_AW-1:0] last_ff, last_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (sweep_cmd.go) begin
         busy_in = 1'b1;
         cnt_in  = sweep_cmd.first;
         last_in = sweep_cmd.last;
      end else if (busy_ff) begin
         if (cnt_ff == last_ff) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + MEM_AW'(1);
         end
      end
   end

   // Reset starts a full pass so the whole array reads as erased.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         last_ff <= LAST_CELL;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   assign busy     = busy_ff;
   assign cur_addr = cnt_ff;

endmodule

### src/fsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command controller
// Command mode machine, bank register and access sequencing.
// ----------------------------------------------------------------------------
module fsc_ctrl
   import fsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              sweep_busy,
   output sweep_cmd_type     sweep_cmd,
   output mem_ctl_type       mem_ctl,
   output rsp_ctl_type       rsp_ctl
);

   mode_type mode_ff, mode_in;
   seq_type  seq_ff, seq_in;
   logic     bank_ff, bank_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     id_hit_ff, id_hit_in;
   logic     id_part_ff, id_part_in;

   logic              accept;
   logic              wr_acc;
   logic              rd_acc;
   logic [MEM_AW-1:0] acc_addr;
   logic              chip_erase;
   logic              sect_erase;
   logic              byte_write;

   assign accept   = req_valid && req_ready;
   assign wr_acc   = accept && req_action;
   assign rd_acc   = accept && !req_action;
   assign acc_addr = cell_addr(bank_ff, req_addr);

   // Command mode machine, advanced by write transactions.
   always_comb begin
      mode_in    = mode_ff;
      bank_in    = bank_ff;
      chip_erase = 1'b0;
      sect_erase = 1'b0;
      byte_write = 1'b0;
      if (wr_acc) begin
         if (mode_ff == MODE_BANK_ARMED && req_addr == ID_ADDR_MAKER) begin
            bank_in = (BANK_COUNT > 1) ? req_byte[0] : 1'b0;
            mode_in = MODE_READY;
         end else begin
            unique case (mode_ff)
               MODE_READY: begin
                  if (req_byte == UNLOCK_BYTE_A && req_addr == UNLOCK_ADDR_A) begin
                     mode_in = MODE_UNLOCK1;
                  end
               end
               MODE_UNLOCK1: begin
                  if (req_byte == UNLOCK_BYTE_B && req_addr == UNLOCK_ADDR_B) begin
                     mode_in = MODE_UNLOCK2;
                  end
               end
               MODE_WRITE_ARMED: begin
                  byte_write = 1'b1;
                  mode_in    = MODE_READY;
               end
               MODE_UNLOCK2, MODE_CHIPID, MODE_ERASE_ARMED, MODE_BANK_ARMED: begin
                  unique case (req_byte)
                     CMD_ID_ENTER:   mode_in = MODE_CHIPID;
                     CMD_ID_EXIT:    mode_in = MODE_READY;
                     CMD_ERASE_ARM:  mode_in = MODE_ERASE_ARMED;
                     CMD_WRITE_ARM:  mode_in = MODE_WRITE_ARMED;
                     CMD_BANK_ARM:   mode_in = MODE_BANK_ARMED;
                     CMD_CHIP_ERASE: begin
                        if (mode_ff == MODE_ERASE_ARMED) begin
                           chip_erase = 1'b1;
                           mode_in    = MODE_READY;
                        end
                     end
                     CMD_SECT_ERASE: begin
                        sect_erase = (mode_ff == MODE_ERASE_ARMED);
                        mode_in    = MODE_READY;
                     end
                     default: mode_in = mode_ff;
                  endcase
               end
               default: mode_in = MODE_READY;
            endcase
         end
      end
   end

   // Access sequencer: a read passes through SEQ_READ while the array read completes.
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (rd_acc) begin
               seq_in = SEQ_READ;
            end
         end
         SEQ_READ: seq_in = SEQ_IDLE;
         default:  seq_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (seq_ff == SEQ_IDLE) && !sweep_busy && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (seq_ff == SEQ_READ) begin
         rsp_valid_in = 1'b1;
      end
      id_hit_in  = id_hit_ff;
      id_part_in = id_part_ff;
      if (rd_acc) begin
         id_hit_in  = (mode_ff == MODE_CHIPID) &&
                      (req_addr == ID_ADDR_MAKER || req_addr == ID_ADDR_PART);
         id_part_in = (req_addr == ID_ADDR_PART);
      end

      sweep_cmd.go    = chip_erase || sect_erase;
      sweep_cmd.first = chip_erase ? '0 : (acc_addr & ~SECTOR_MASK);
      sweep_cmd.last  = chip_erase ? LAST_CELL : (acc_addr | SECTOR_MASK);

      mem_ctl.wr_en   = byte_write;
      mem_ctl.wr_addr = acc_addr;
      mem_ctl.wr_data = req_byte;
      mem_ctl.rd_en   = rd_acc;
      mem_ctl.rd_addr = acc_addr;

      rsp_ctl.load    = (seq_ff == SEQ_READ);
      rsp_ctl.id_hit  = id_hit_ff;
      rsp_ctl.id_part = id_part_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_READY;
         seq_ff       <= SEQ_IDLE;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         seq_ff       <= seq_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_hit_ff  <= id_hit_in;
      id_part_ff <= id_part_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/flash_save_command_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash save command controller
// Banked 128 KB flash save chip model behind a byte-wide bus access stream.
// ----------------------------------------------------------------------------
// Each request transaction is one bus access: a write feeds the command mode
// machine (unlock pair, ID mode, erase, byte write, bank select) and gives no
// response, a read gives one response transaction with the stored byte or,
// in ID mode at an ID address, an ID register. A read passes through the
// registered read port of the single-port-pair array RAM to its response.
// The array is erased by one sweep unit that writes one cell per cycle: after
// reset it clears all 131072 cells before the first request is taken, a chip
// erase stalls requests over all cells and a sector erase over its 4096 cells.
// The ID registers may be written at any time through the csr port.
module flash_save_command_controller
   import fsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // bus_address[27:0], write_byte[35:28]
   input  logic                   req_tuser,   // action: 0 read, 1 write
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // read_byte[7:0]
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   logic [DATA_W-1:0] maker_id_ff, maker_id_in;
   logic [DATA_W-1:0] part_id_ff, part_id_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0] req_addr;
   logic [DATA_W-1:0] req_byte;
   sweep_cmd_type     sweep_cmd;
   mem_ctl_type       mem_ctl;
   rsp_ctl_type       rsp_ctl;
   logic              sweep_busy;
   logic [MEM_AW-1:0] sweep_cell;
   logic              ram_wr_en;
   logic [MEM_AW-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [DATA_W-1:0] ram_rd_data;

   assign req_addr = req_tdata[ADDR_W-1:0];
   assign req_byte = req_tdata[ADDR_W+DATA_W-1:ADDR_W];

   fsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_addr   (req_addr),
      .req_byte   (req_byte),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .sweep_busy (sweep_busy),
      .sweep_cmd  (sweep_cmd),
      .mem_ctl    (mem_ctl),
      .rsp_ctl    (rsp_ctl)
   );

   fsc_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .sweep_cmd (sweep_cmd),
      .busy      (sweep_busy),
      .cur_addr  (sweep_cell)
   );

   // The sweep owns the write port while it runs; no request is taken then.
   always_comb begin
      if (sweep_busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_cell;
         ram_wr_data = ERASED_BYTE;
      end else begin
         ram_wr_en   = mem_ctl.wr_en;
         ram_wr_addr = mem_ctl.wr_addr;
         ram_wr_data = mem_ctl.wr_data;
      end
   end

   fsc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TOTAL_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      maker_id_in = maker_id_ff;
      part_id_in  = part_id_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAKER_ID: maker_id_in = csr_wdata;
            CSR_PART_ID:  part_id_in  = csr_wdata;
            default:      maker_id_in = maker_id_ff;
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_ctl.load) begin
         if (rsp_ctl.id_hit) begin
            rsp_data_in = rsp_ctl.id_part ? part_id_ff : maker_id_ff;
         end else begin
            rsp_data_in = ram_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maker_id_ff <= 8'hC2;
         part_id_ff  <= 8'h09;
      end else begin
         maker_id_ff <= maker_id_in;
         part_id_ff  <= part_id_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
